// File: hw/rtl/rgb_palette_indexer_core_macros.svh
// Assertion macros shared by the palette indexer checker.
// No dependencies; included by the checker file.
`ifndef RGB_PALETTE_INDEXER_CORE_MACROS_SVH
`define RGB_PALETTE_INDEXER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RGBPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define RGBPI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/rgbpi_pkg.sv
// Shared types and constants for the palette indexer.
// No dependencies; used by every module of the block.
`default_nettype none
package rgbpi_pkg;

	localparam int IDX_W   = 8;
	localparam int RGB_W   = 24;
	localparam int X_W     = 8;
	localparam int Y_W     = 10;
	localparam int ALPHA_W = 8;
	localparam int ADDR_W  = 18;
	localparam int WIDTH_W = 9;

	localparam int DEF_PALETTE_ENTRIES = 255;
	localparam int DEF_MAX_WIDTH       = 256;

	// leaves per first-level reduction group
	localparam int TREE_WAYS = 16;

	localparam logic [RGB_W-1:0] WHITE_RGB = 24'hFFFFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_REDUCE,
		ST_DECIDE
	} state_t;

	// broadcast from the sequencer to every cell of the row
	typedef struct packed {
		logic             shift_en;
		logic [IDX_W-1:0] used_cnt;
		logic [RGB_W-1:0] query;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/rgb_palette_indexer_core.sv
// Top level of the palette indexer: sequencer, cell row, reduction and result register.
// Depends on rgbpi_pkg, rgbpi_cell and rgbpi_or_tree.
//
// channel | signals                                      | flow
// --------+----------------------------------------------+-------------------
// in      | in_valid/in_ready, pixel_x/y, rgb, alpha     | one pixel word in
// out     | out_valid/out_ready, address, index, flags   | one result word out
// cfg     | cfg_wr_en, cfg_wr_data                       | pattern width write
//
// A pixel word passes through capture, compare in every cell, group
// reduction, and decide and append, in that order. The compare over the
// cell row and the two reduction levels set these steps.
// Reset empties the palette (fill count to zero) and sets the width to zero.
// A new word is taken while a finished result waits; the decide step holds
// until the output register is free.
`default_nettype none
module rgb_palette_indexer_core #(
	parameter int PALETTE_ENTRIES = rgbpi_pkg::DEF_PALETTE_ENTRIES,
	parameter int MAX_WIDTH       = rgbpi_pkg::DEF_MAX_WIDTH
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_wr_en,
	input  wire  [rgbpi_pkg::WIDTH_W-1:0]       cfg_wr_data,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [rgbpi_pkg::X_W-1:0]           pixel_x,
	input  wire  [rgbpi_pkg::Y_W-1:0]           pixel_y,
	input  wire  [rgbpi_pkg::RGB_W-1:0]         rgb_value,
	input  wire  [rgbpi_pkg::ALPHA_W-1:0]       alpha_value,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [rgbpi_pkg::ADDR_W-1:0]        pixel_address,
	output logic [rgbpi_pkg::IDX_W-1:0]         palette_index,
	output logic                                color_added,
	output logic                                palette_full
);

	localparam int GROUPS = (PALETTE_ENTRIES + rgbpi_pkg::TREE_WAYS - 1) / rgbpi_pkg::TREE_WAYS;
	localparam int PROD_W = rgbpi_pkg::WIDTH_W + rgbpi_pkg::Y_W;
	localparam logic [rgbpi_pkg::IDX_W:0] ENTRIES_EXT = (rgbpi_pkg::IDX_W+1)'(PALETTE_ENTRIES);

	rgbpi_pkg::state_t state_q, state_nxt;

	logic [rgbpi_pkg::WIDTH_W-1:0] width_q;
	logic [rgbpi_pkg::IDX_W-1:0]   count_q;
	logic [rgbpi_pkg::X_W-1:0]     x_q;
	logic [rgbpi_pkg::Y_W-1:0]     y_q;
	logic [rgbpi_pkg::RGB_W-1:0]   rgb_q;
	logic                          bg_q;
	logic [rgbpi_pkg::ADDR_W-1:0]  addr_q;

	logic                          out_valid_q;
	logic [rgbpi_pkg::ADDR_W-1:0]  out_addr_q;
	logic [rgbpi_pkg::IDX_W-1:0]   out_idx_q;
	logic                          out_added_q;
	logic                          out_full_q;

	logic                          accept;
	logic                          out_load;
	logic                          append;
	logic [rgbpi_pkg::IDX_W-1:0]   hit_all;
	logic [rgbpi_pkg::IDX_W-1:0]   res_idx;
	logic                          res_added;
	logic                          res_full;
	logic [PROD_W-1:0]             prod;

	rgbpi_pkg::cell_ctrl_t         ctrl;

	logic [rgbpi_pkg::RGB_W-1:0]   colors   [PALETTE_ENTRIES];
	logic [rgbpi_pkg::IDX_W-1:0]   hit_code [PALETTE_ENTRIES];
	logic [GROUPS-1:0][rgbpi_pkg::TREE_WAYS-1:0][rgbpi_pkg::IDX_W-1:0] grp_in;
	logic [rgbpi_pkg::IDX_W-1:0]   grp_out  [GROUPS];

	assign accept = in_valid && in_ready;

	// width register, saturated at the maximum pattern width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
		end else if (cfg_wr_en) begin
			if (32'(cfg_wr_data) > 32'(MAX_WIDTH)) begin
				width_q <= rgbpi_pkg::WIDTH_W'(MAX_WIDTH);
			end else begin
				width_q <= cfg_wr_data;
			end
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and handshake
	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			rgbpi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = rgbpi_pkg::ST_COMPARE;
				end
			end
			rgbpi_pkg::ST_COMPARE: begin
				state_nxt = rgbpi_pkg::ST_REDUCE;
			end
			rgbpi_pkg::ST_REDUCE: begin
				state_nxt = rgbpi_pkg::ST_DECIDE;
			end
			rgbpi_pkg::ST_DECIDE: begin
				if (!out_valid_q || out_ready) begin
					out_load  = 1'b1;
					state_nxt = rgbpi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rgbpi_pkg::ST_IDLE;
			end
		endcase
	end

	// capture the pixel word
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= pixel_x;
			y_q   <= pixel_y;
			rgb_q <= rgb_value;
			bg_q  <= (rgb_value == rgbpi_pkg::WHITE_RGB) || (alpha_value == '0);
		end
	end

	// linear address, formed while the cells compare
	assign prod = PROD_W'(width_q) * PROD_W'(y_q);

	always_ff @(posedge clk) begin
		if (state_q == rgbpi_pkg::ST_COMPARE) begin
			addr_q <= rgbpi_pkg::ADDR_W'(prod) + rgbpi_pkg::ADDR_W'(x_q);
		end
	end

	// cell row
	assign ctrl.shift_en = append;
	assign ctrl.used_cnt = count_q;
	assign ctrl.query    = rgb_q;

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			rgbpi_cell #(.POS(i)) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.color_in (rgb_q),
				.color_out(colors[i]),
				.hit_code (hit_code[i])
			);
		end else begin : g_body
			rgbpi_cell #(.POS(i)) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.color_in (colors[i-1]),
				.color_out(colors[i]),
				.hit_code (hit_code[i])
			);
		end
	end

	// first reduction level, padded with zero codes
	for (genvar g = 0; g < GROUPS; g++) begin : g_grp
		for (genvar k = 0; k < rgbpi_pkg::TREE_WAYS; k++) begin : g_leaf
			if (g * rgbpi_pkg::TREE_WAYS + k < PALETTE_ENTRIES) begin : g_real
				assign grp_in[g][k] = hit_code[g * rgbpi_pkg::TREE_WAYS + k];
			end else begin : g_pad
				assign grp_in[g][k] = '0;
			end
		end
		rgbpi_or_tree #(.LEAVES(rgbpi_pkg::TREE_WAYS)) u_tree (
			.clk    (clk),
			.leaf   (grp_in[g]),
			.grp_out(grp_out[g])
		);
	end

	// final level and decision
	always_comb begin
		hit_all = '0;
		for (int g = 0; g < GROUPS; g++) begin
			hit_all = hit_all | grp_out[g];
		end
	end

	always_comb begin
		res_idx   = '0;
		res_added = 1'b0;
		res_full  = 1'b0;
		priority if (bg_q) begin
			res_idx = '0;
		end else if (hit_all != '0) begin
			// cell code p+1 holds palette index count-p
			res_idx = count_q + rgbpi_pkg::IDX_W'(1) - hit_all;
		end else if ({1'b0, count_q} < ENTRIES_EXT) begin
			res_idx   = count_q + rgbpi_pkg::IDX_W'(1);
			res_added = 1'b1;
		end else begin
			res_full = 1'b1;
		end
	end

	assign append = out_load && res_added;

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (append) begin
			count_q <= count_q + rgbpi_pkg::IDX_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_addr_q  <= addr_q;
			out_idx_q   <= res_idx;
			out_added_q <= res_added;
			out_full_q  <= res_full;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = out_addr_q;
	assign palette_index = out_idx_q;
	assign color_added   = out_added_q;
	assign palette_full  = out_full_q;

endmodule
`default_nettype wire

// File: hw/rtl/rgbpi_cell.sv
// One palette cell: holds a color, shifts it to its neighbor on append,
// and compares it against the query. Depends on rgbpi_pkg.
`default_nettype none
module rgbpi_cell #(
	parameter int POS = 0
) (
	input  wire                               clk,
	input  rgbpi_pkg::cell_ctrl_t             ctrl,
	input  wire  [rgbpi_pkg::RGB_W-1:0]       color_in,
	output logic [rgbpi_pkg::RGB_W-1:0]       color_out,
	output logic [rgbpi_pkg::IDX_W-1:0]       hit_code
);

	localparam logic [rgbpi_pkg::IDX_W-1:0] MY_POS  = rgbpi_pkg::IDX_W'(POS);
	localparam logic [rgbpi_pkg::IDX_W-1:0] MY_CODE = rgbpi_pkg::IDX_W'(POS + 1);

	logic [rgbpi_pkg::RGB_W-1:0] color_q;
	logic [rgbpi_pkg::IDX_W-1:0] hit_q;
	logic                        in_use;

	// newest color enters cell 0, older ones move one place down the row
	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			color_q <= color_in;
		end
	end

	// cell holds a live entry only below the fill count
	assign in_use = (MY_POS < ctrl.used_cnt);

	// colors in the row are unique, so at most one cell reports a hit
	always_ff @(posedge clk) begin
		hit_q <= (in_use && (color_q == ctrl.query)) ? MY_CODE : '0;
	end

	assign color_out = color_q;
	assign hit_code  = hit_q;

endmodule
`default_nettype wire

// File: hw/rtl/rgbpi_or_tree.sv
// Registered OR reduction over one group of cell hit codes.
// Depends on rgbpi_pkg.
`default_nettype none
module rgbpi_or_tree #(
	parameter int LEAVES = rgbpi_pkg::TREE_WAYS
) (
	input  wire                                       clk,
	input  wire  [LEAVES-1:0][rgbpi_pkg::IDX_W-1:0]   leaf,
	output logic [rgbpi_pkg::IDX_W-1:0]               grp_out
);

	logic [rgbpi_pkg::IDX_W-1:0] acc;
	logic [rgbpi_pkg::IDX_W-1:0] grp_q;

	// independent OR across the group
	always_comb begin
		acc = '0;
		for (int k = 0; k < LEAVES; k++) begin
			acc = acc | leaf[k];
		end
	end

	always_ff @(posedge clk) begin
		grp_q <= acc;
	end

	assign grp_out = grp_q;

endmodule
`default_nettype wire

// File: hw/rtl/rgbpi_checker.sv
// Port-level checks for the palette indexer, bound to the top level.
// Depends on rgbpi_pkg and rgb_palette_indexer_core_macros.svh.
`default_nettype none
`include "rgb_palette_indexer_core_macros.svh"
module rgbpi_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              out_valid,
	input wire                              out_ready,
	input wire                              in_valid,
	input wire                              in_ready,
	input wire [rgbpi_pkg::IDX_W-1:0]       palette_index,
	input wire                              color_added,
	input wire                              palette_full
);

	// a result word stays until taken
	`RGBPI_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// an appended color always gets a nonzero index
	`RGBPI_ASSERT_IMP(a_added_idx, clk, arst_n, out_valid && color_added, palette_index != '0)

	// a refused color maps to background and is never also appended
	`RGBPI_ASSERT_IMP(a_full_idx, clk, arst_n, out_valid && palette_full,
		(palette_index == '0) && !color_added)

	// one word in the sequencer: no new word taken in the cycle after an accept
	`RGBPI_ASSERT_NXT(a_one_flight, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind rgb_palette_indexer_core rgbpi_checker u_rgbpi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.palette_index(palette_index),
	.color_added  (color_added),
	.palette_full (palette_full)
);
`default_nettype wire
